FILE: src/gbnms_pkg.sv
// Shared constants for the greedy box non-maximum suppression block.
package gbnms_pkg;

    localparam int IN_COORD_W = 12;
    localparam int THR_W      = 9;
    localparam int SLOT_W     = 6;
    localparam int TOTAL_W    = 7;

    localparam logic [THR_W-1:0] THR_RESET = 9'd166;

endpackage

FILE: src/gbnms_cell.sv
// One cell of the kept-box ring: holds one box, loads a new one or takes its neighbor's.
module gbnms_cell #(
    parameter int W = 48
) (
    input  logic         aclk,
    input  logic         shift_en,
    input  logic         load_en,
    input  logic [W-1:0] load_data,
    input  logic [W-1:0] shift_data,
    output logic [W-1:0] data_reg
);

    logic [W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (load_en) begin
            data_next = load_data;
        end else if (shift_en) begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: src/gbnms_iou.sv
// Pipelined IoU threshold test of the current box against one kept box per cycle.
module gbnms_iou
    import gbnms_pkg::*;
#(
    parameter int CB = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [CB-1:0]      a_x,
    input  logic [CB-1:0]      a_y,
    input  logic [CB-1:0]      a_w,
    input  logic [CB-1:0]      a_h,
    input  logic [2*CB-1:0]    a_area,
    input  logic [CB-1:0]      b_x,
    input  logic [CB-1:0]      b_y,
    input  logic [CB-1:0]      b_w,
    input  logic [CB-1:0]      b_h,
    input  logic [THR_W-1:0]   thr,
    output logic               hit_valid_reg,
    output logic               hit_reg,
    output logic               busy
);

    localparam int OW = CB + 1;
    localparam int IW = 2 * OW;
    localparam int PW = IW + THR_W;

    logic [OW-1:0] ox_next, oy_next;
    logic [OW-1:0] ox_reg, oy_reg;
    logic [2*CB-1:0] barea1_reg, barea2_reg;
    logic [IW-1:0] inter2_reg, inter3_reg, inter4_reg;
    logic [IW-1:0] uni3_reg;
    logic [PW-1:0] prod4_reg;
    logic uz4_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    function automatic logic [OW-1:0] overlap(input logic [CB-1:0] a0, input logic [CB-1:0] al,
                                              input logic [CB-1:0] b0, input logic [CB-1:0] bl);
        logic [OW-1:0] a1, b1, lo, hi;
        a1 = OW'(a0) + OW'(al);
        b1 = OW'(b0) + OW'(bl);
        lo = (a0 > b0) ? OW'(a0) : OW'(b0);
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? hi - lo : '0;
    endfunction

    always_comb begin
        ox_next = overlap(a_x, a_w, b_x, b_w);
        oy_next = overlap(a_y, a_h, b_y, b_h);
    end

    always_ff @(posedge aclk) begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        barea1_reg <= b_w * b_h;
        inter2_reg <= ox_reg * oy_reg;
        barea2_reg <= barea1_reg;
        uni3_reg   <= IW'(a_area) + IW'(barea2_reg) - inter2_reg;
        inter3_reg <= inter2_reg;
        prod4_reg  <= PW'(thr) * PW'(uni3_reg);
        uz4_reg    <= (uni3_reg == '0);
        inter4_reg <= inter3_reg;
        hit_reg    <= !uz4_reg && ({inter4_reg, 8'b0} > PW'(prod4_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            hit_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            hit_valid_reg <= v4_reg;
        end
    end

    assign busy = v1_reg | v2_reg | v3_reg | v4_reg | hit_valid_reg;

endmodule

FILE: src/greedy_box_nms_unit.sv
// Greedy IoU non-maximum suppression over a ring of kept-box cells.
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  request | s_valid s_ready s_start_new_set s_box_*           | in
//  result  | m_valid m_ready m_keep m_kept_slot m_list_full ... | out
//  config  | cfg_we cfg_wdata (IoU threshold, 1/256 units)     | in
//
//  After a request is taken, the ring rotates once past the shared 5-stage IoU
//  unit, one kept box per cycle, the pipeline drains, then the result is stored.
//  The next request is taken the cycle after the result is registered.
//  Reset clears the kept count and loads the threshold with 166.
//  A stalled result holds the block only when the next result is ready to go out.
module greedy_box_nms_unit
    import gbnms_pkg::*;
#(
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_start_new_set,
    input  logic [IN_COORD_W-1:0] s_box_left,
    input  logic [IN_COORD_W-1:0] s_box_top,
    input  logic [IN_COORD_W-1:0] s_box_width,
    input  logic [IN_COORD_W-1:0] s_box_height,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_keep,
    output logic [SLOT_W-1:0]     m_kept_slot,
    output logic                  m_list_full,
    output logic [TOTAL_W-1:0]    m_kept_total
);

    localparam int CB = COORD_BITS;
    localparam int BW = 4 * CB;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int EW = (CB > IN_COORD_W) ? CB : IN_COORD_W;
    localparam logic [CB-1:0] COORD_MAX = '1;

    typedef enum logic [2:0] {ST_IDLE, ST_AREA, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

    state_t state_reg;
    logic [THR_W-1:0] thr_reg;
    logic [CW-1:0] count_reg, step_reg;
    logic supp_reg;
    logic [CB-1:0] cx_reg, cy_reg, cw_reg, ch_reg;
    logic [2*CB-1:0] carea_reg;
    logic m_valid_reg, keep_reg, full_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [BW-1:0] ring [MAX_KEPT];
    logic out_go, wr, scan_issue;
    logic hit_valid, hit, iou_busy;

    function automatic logic [CB-1:0] clamp(input logic [IN_COORD_W-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        return (e > EW'(COORD_MAX)) ? COORD_MAX : CB'(e);
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign out_go     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign wr         = out_go && !supp_reg && (count_reg < CW'(MAX_KEPT));
    assign scan_issue = (state_reg == ST_SCAN) && (step_reg < count_reg);

    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_ring
        gbnms_cell #(.W(BW)) u_cell (
            .aclk      (aclk),
            .shift_en  (state_reg == ST_SCAN),
            .load_en   (wr && (count_reg == CW'(i))),
            .load_data ({cx_reg, cy_reg, cw_reg, ch_reg}),
            .shift_data(ring[(i + 1) % MAX_KEPT]),
            .data_reg  (ring[i])
        );
    end

    gbnms_iou #(.CB(CB)) u_iou (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (scan_issue),
        .a_x          (cx_reg),
        .a_y          (cy_reg),
        .a_w          (cw_reg),
        .a_h          (ch_reg),
        .a_area       (carea_reg),
        .b_x          (ring[0][4*CB-1:3*CB]),
        .b_y          (ring[0][3*CB-1:2*CB]),
        .b_w          (ring[0][2*CB-1:CB]),
        .b_h          (ring[0][CB-1:0]),
        .thr          (thr_reg),
        .hit_valid_reg(hit_valid),
        .hit_reg      (hit),
        .busy         (iou_busy)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cx_reg <= clamp(s_box_left);
            cy_reg <= clamp(s_box_top);
            cw_reg <= clamp(s_box_width);
            ch_reg <= clamp(s_box_height);
        end
        if (state_reg == ST_AREA) begin
            carea_reg <= cw_reg * ch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THR_RESET;
            count_reg   <= '0;
            step_reg    <= '0;
            supp_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            keep_reg    <= 1'b0;
            full_reg    <= 1'b0;
            slot_reg    <= '0;
            total_reg   <= '0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (m_ready && !out_go) begin
                m_valid_reg <= 1'b0;
            end
            if (hit_valid && hit) begin
                supp_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_start_new_set) begin
                            count_reg <= '0;
                        end
                        supp_reg  <= 1'b0;
                        step_reg  <= '0;
                        state_reg <= ST_AREA;
                    end
                end
                ST_AREA: begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == CW'(MAX_KEPT - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!iou_busy) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_go) begin
                        m_valid_reg <= 1'b1;
                        keep_reg    <= !supp_reg;
                        full_reg    <= !supp_reg && !wr;
                        slot_reg    <= wr ? SLOT_W'(count_reg) : '0;
                        total_reg   <= wr ? TOTAL_W'(count_reg + 1'b1) : TOTAL_W'(count_reg);
                        if (wr) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_keep       = keep_reg;
    assign m_kept_slot  = slot_reg;
    assign m_list_full  = full_reg;
    assign m_kept_total = total_reg;

endmodule
